// File: src/rse_pkg.sv
package rse_pkg;

	localparam int MEM_WORDS = 65536;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int REG_COUNT = 32;
	localparam int REG_AW    = $clog2(REG_COUNT);
	localparam int OP_KINDS  = 10;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_ADDI = 4'd3;
	localparam logic [3:0] OP_SLT  = 4'd4;
	localparam logic [3:0] OP_J    = 4'd5;
	localparam logic [3:0] OP_BNE  = 4'd6;
	localparam logic [3:0] OP_BEQ  = 4'd7;
	localparam logic [3:0] OP_SW   = 4'd8;
	localparam logic [3:0] OP_LW   = 4'd9;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_ZERO_REG = 2'd1;
	localparam logic [1:0] STS_MISALIGN = 2'd2;
	localparam logic [1:0] STS_RANGE    = 2'd3;

	typedef struct packed {
		logic [3:0]          op;
		logic [4:0]          first_reg;
		logic [4:0]          second_reg;
		logic [4:0]          third_reg;
		logic                use_imm;
		logic signed [31:0]  imm;
		logic [15:0]         line_index;
		logic [15:0]         target_line;
	} req_t;

	typedef struct packed {
		logic [15:0]         next_line;
		logic [1:0]          status;
		logic                wrote_reg;
		logic [4:0]          dest_index;
		logic signed [31:0]  dest_value;
		logic [31:0]         op_count;
		logic [31:0]         total_count;
	} res_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic rd;
		logic ex;
		logic mem;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_sts_t;

endpackage

// File: src/rse_ctrl.sv
module rse_ctrl import rse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    res_valid,
	input  logic    res_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EX   = 3'd3;
	localparam logic [2:0] S_MEM  = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EX;
			end
			S_EX: begin
				cmd.ex  = 1'b1;
				state_d = S_MEM;
			end
			S_MEM: begin
				cmd.mem = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				// result register must be free or draining this cycle
				if (!res_valid_q || res_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;

endmodule

// File: src/rse_dp.sv
module rse_dp import rse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output res_t    res
);

	// request and register file
	req_t                 item_q;
	logic [31:0]          rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;
	logic [REG_AW-1:0]    rf_ra, rf_rb;
	logic [31:0]          rda_s1, rdb_s1;
	logic                 vla_s1, vlb_s1;

	// execute
	logic [31:0] opa, opb_reg, opb;
	logic [31:0] alu_res;
	logic [31:0] alu_s2, addr_s2, st_data_s2;
	logic        taken_s2;

	// memory stage
	logic [31:0]        dmem [MEM_WORDS];
	logic [MEM_AW-1:0]  clr_q;
	logic [MEM_AW-1:0]  dm_wa;
	logic [31:0]        dm_wd;
	logic               dm_we, dm_re;
	logic [31:0]        dm_rdata_s3;
	logic [1:0]         status;
	logic [1:0]         status_s3;
	logic               is_alu, is_mem, is_br, op_ok;

	// counters
	logic [31:0] cnt_q [OP_KINDS];
	logic [31:0] total_q;
	logic [31:0] cnt_next, total_next;
	logic        wrote;
	logic [31:0] wval;
	res_t        res_q;

	always_comb begin
		is_alu = 1'b0;
		is_mem = 1'b0;
		is_br  = 1'b0;
		op_ok  = 1'b1;
		unique case (item_q.op) inside
			OP_ADD, OP_SUB, OP_MUL, OP_ADDI, OP_SLT: is_alu = 1'b1;
			OP_BNE, OP_BEQ:                          is_br  = 1'b1;
			OP_SW, OP_LW:                            is_mem = 1'b1;
			OP_J:                                    ;
			default:                                 op_ok  = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= req;
	end

	// port a: base or first source, port b: second source or store data
	always_comb begin
		rf_ra = is_br ? item_q.first_reg : item_q.second_reg;
		if (is_alu) rf_rb = item_q.third_reg;
		else if (is_br) rf_rb = item_q.second_reg;
		else rf_rb = item_q.first_reg;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rda_s1 <= rf_mem[rf_ra];
			rdb_s1 <= rf_mem[rf_rb];
			vla_s1 <= rf_vld_q[rf_ra];
			vlb_s1 <= rf_vld_q[rf_rb];
		end
		if (cmd.commit && wrote) rf_mem[item_q.first_reg] <= wval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (cmd.commit && wrote) begin
			rf_vld_q[item_q.first_reg] <= 1'b1;
		end
	end

	assign opa     = vla_s1 ? rda_s1 : '0;
	assign opb_reg = vlb_s1 ? rdb_s1 : '0;
	assign opb     = (item_q.op == OP_ADDI || item_q.use_imm) ? item_q.imm : opb_reg;

	always_comb begin
		unique case (item_q.op) inside
			OP_ADD, OP_ADDI: alu_res = opa + opb;
			OP_SUB:          alu_res = opa - opb;
			OP_MUL:          alu_res = opa * opb;
			OP_SLT:          alu_res = {31'd0, $signed(opa) < $signed(opb)};
			default:         alu_res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.ex) begin
			alu_s2     <= alu_res;
			addr_s2    <= item_q.imm + opa;
			st_data_s2 <= opb_reg;
			taken_s2   <= (item_q.op == OP_J) ||
				(item_q.op == OP_BEQ && opa == opb) ||
				(item_q.op == OP_BNE && opa != opb);
		end
	end

	// zero register first, then alignment, then range
	always_comb begin
		status = STS_OK;
		if ((is_alu || is_mem) && item_q.first_reg == '0) status = STS_ZERO_REG;
		else if (is_mem && addr_s2[1:0] != 2'd0) status = STS_MISALIGN;
		else if (is_mem && (addr_s2[31] || addr_s2[31:2] >= 30'(MEM_WORDS)))
			status = STS_RANGE;
	end

	assign dm_we = cmd.clear || (cmd.mem && item_q.op == OP_SW && status == STS_OK);
	assign dm_re = cmd.mem && item_q.op == OP_LW && status == STS_OK;
	assign dm_wa = cmd.clear ? clr_q : addr_s2[MEM_AW+1:2];
	assign dm_wd = cmd.clear ? '0 : st_data_s2;

	always_ff @(posedge clk) begin
		if (dm_we) dmem[dm_wa] <= dm_wd;
		if (dm_re) dm_rdata_s3 <= dmem[addr_s2[MEM_AW+1:2]];
		if (cmd.mem) status_s3 <= status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign sts.clr_last = (clr_q == MEM_AW'(MEM_WORDS - 1));

	// write back and count
	assign wrote      = op_ok && (is_alu || item_q.op == OP_LW) && status_s3 == STS_OK;
	assign wval       = is_alu ? alu_s2 : dm_rdata_s3;
	assign cnt_next   = op_ok ? cnt_q[item_q.op] + 32'd1 : '0;
	assign total_next = op_ok ? total_q + 32'd1 : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OP_KINDS; i++) cnt_q[i] <= '0;
			total_q <= '0;
		end else if (cmd.commit && op_ok) begin
			cnt_q[item_q.op] <= cnt_next;
			total_q          <= total_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.next_line   <= taken_s2 ? item_q.target_line : item_q.line_index;
			res_q.status      <= status_s3;
			res_q.wrote_reg   <= wrote;
			res_q.dest_index  <= wrote ? item_q.first_reg : '0;
			res_q.dest_value  <= wrote ? wval : '0;
			res_q.op_count    <= cnt_next;
			res_q.total_count <= total_next;
		end
	end

	assign res = res_q;

endmodule

// File: src/risc_subset_execute_unit.sv
// executes one decoded instruction of a small risc subset per request
// request channel: req_valid / req_ready with payload req (op, register
// indexes, immediate, line index, target line); taken when both are high
// result channel: res_valid / res_ready with payload res (next line,
// status, register write-back, per-op count and total count)
// an accepted request walks through operand read, execute (alu, multiply,
// address add), data memory access and write-back, in that order
// the result is valid once write-back commits it to the output register
// a new request waits for write-back, as the single sequencer walks each
// request through the register file and data memory ports
// a finished result sits in the output register; a new request is taken
// while it waits, and write-back holds until res_ready frees the register
// reset clears the register file valid bits and all counters, then a
// clearing pass writes zero to every data memory word, one per cycle,
// with req_ready low until it ends
module risc_subset_execute_unit import rse_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rse_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

endmodule

// File: tb/risc_subset_execute_unit_tb.sv
`timescale 1ns / 1ps
module risc_subset_execute_unit_tb;
	import rse_pkg::*;

	localparam int         LIMIT_CYCLES = 600000;
	localparam int         RANDOM_ITEMS = 2000;
	localparam int         MAX_WAIT     = 12;
	localparam int         DRAIN_CYCLES = 20;
	localparam logic [3:0] OP_CODE_MAX  = 4'hF;

	class exec_scoreboard;
		logic [31:0] regs [REG_COUNT];
		logic [31:0] mem_image [int unsigned];
		logic [31:0] op_tally [OP_KINDS];
		logic [31:0] total_tally;
		res_t        expected_results [$];
		int unsigned failures;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (op_tally[i]) op_tally[i] = '0;
			total_tally = '0;
			failures = 0;
		endfunction

		function logic [31:0] reg_value(logic [4:0] idx);
			return regs[idx];
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// executes the instruction on the local copy of the state and queues its result
		function void note_request(req_t r);
			res_t        o;
			logic [31:0] a, b, v, addr;
			o = '0;
			o.next_line = r.line_index;
			o.status = STS_OK;
			if (r.op < OP_KINDS) begin
				op_tally[r.op] += 1;
				total_tally += 1;
				o.op_count = op_tally[r.op];
				case (r.op) inside
				OP_ADD, OP_SUB, OP_MUL, OP_ADDI, OP_SLT: begin
					a = regs[r.second_reg];
					b = (r.op == OP_ADDI || r.use_imm) ? r.imm : regs[r.third_reg];
					case (r.op)
					OP_SUB:  v = a - b;
					OP_MUL:  v = a * b;
					OP_SLT:  v = {31'd0, $signed(a) < $signed(b)};
					default: v = a + b;
					endcase
					if (r.first_reg == 0) begin
						o.status = STS_ZERO_REG;
					end else begin
						regs[r.first_reg] = v;
						o.wrote_reg = 1'b1;
						o.dest_index = r.first_reg;
						o.dest_value = v;
					end
				end
				OP_J: begin
					o.next_line = r.target_line;
				end
				OP_BNE, OP_BEQ: begin
					a = regs[r.first_reg];
					b = r.use_imm ? r.imm : regs[r.second_reg];
					if ((r.op == OP_BEQ) == (a == b)) o.next_line = r.target_line;
				end
				default: begin
					addr = r.imm + regs[r.second_reg];
					// zero register first, then alignment, then range
					if (r.first_reg == 0) begin
						o.status = STS_ZERO_REG;
					end else if (addr[1:0] != 2'd0) begin
						o.status = STS_MISALIGN;
					end else if (addr[31] || addr[31:2] >= MEM_WORDS) begin
						o.status = STS_RANGE;
					end else if (r.op == OP_SW) begin
						mem_image[addr[31:2]] = regs[r.first_reg];
					end else begin
						v = mem_image.exists(addr[31:2]) ? mem_image[addr[31:2]] : '0;
						regs[r.first_reg] = v;
						o.wrote_reg = 1'b1;
						o.dest_index = r.first_reg;
						o.dest_value = v;
					end
				end
				endcase
			end
			o.total_count = total_tally;
			expected_results.insert(expected_results.size(), o);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: %h", got);
				failures++;
				return;
			end
			want = expected_results.pop_front();
			if (got.next_line !== want.next_line) begin
				$error("next_line: expected %0d, got %0d", want.next_line, got.next_line);
				failures++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.wrote_reg !== want.wrote_reg) begin
				$error("wrote_reg: expected %0d, got %0d", want.wrote_reg, got.wrote_reg);
				failures++;
			end
			if (got.dest_index !== want.dest_index) begin
				$error("dest_index: expected %0d, got %0d", want.dest_index, got.dest_index);
				failures++;
			end
			if (got.dest_value !== want.dest_value) begin
				$error("dest_value: expected %h, got %h", want.dest_value, got.dest_value);
				failures++;
			end
			if (got.op_count !== want.op_count) begin
				$error("op_count: expected %0d, got %0d", want.op_count, got.op_count);
				failures++;
			end
			if (got.total_count !== want.total_count) begin
				$error("total_count: expected %0d, got %0d", want.total_count, got.total_count);
				failures++;
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           req_valid;
	logic           req_ready;
	req_t           req;
	logic           res_valid;
	logic           res_ready;
	res_t           res;
	int unsigned    cycles = 0;
	int             send_burst = 0;
	int             recv_burst = 0;
	exec_scoreboard sb;

	risc_subset_execute_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// mostly random waits, with occasional runs of back-to-back transfers
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic req_t make_req(logic [3:0] op, logic [4:0] fr, logic [4:0] sr,
			logic [4:0] tr, logic ui, logic [31:0] imm, logic [15:0] line,
			logic [15:0] target);
		req_t r;
		r.op = op;
		r.first_reg = fr;
		r.second_reg = sr;
		r.third_reg = tr;
		r.use_imm = ui;
		r.imm = imm;
		r.line_index = line;
		r.target_line = target;
		return r;
	endfunction

	function automatic logic [31:0] random_imm();
		case ($urandom_range(0, 3))
		0: return 32'($urandom_range(0, 32)) - 32'd16;
		1: begin
			case ($urandom_range(0, 3))
			0:       return 32'h0000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h8000_0000;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		default: return $urandom();
		endcase
	endfunction

	function automatic req_t random_request();
		req_t        r;
		logic [31:0] base;
		int unsigned word;
		int          roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) r.op = 4'($urandom_range(OP_KINDS, OP_CODE_MAX));
		else if (roll < 35) r.op = $urandom_range(0, 1) ? OP_SW : OP_LW;
		else r.op = 4'($urandom_range(OP_ADD, OP_BEQ));
		r.first_reg = 5'($urandom_range(0, REG_COUNT - 1));
		r.second_reg = 5'($urandom_range(0, REG_COUNT - 1));
		r.third_reg = 5'($urandom_range(0, REG_COUNT - 1));
		r.use_imm = 1'($urandom_range(0, 1));
		r.imm = random_imm();
		r.line_index = 16'($urandom_range(0, 16'hFFFF));
		r.target_line = 16'($urandom_range(0, 16'hFFFF));
		if (r.op == OP_SW || r.op == OP_LW) begin
			// aim at a chosen word, mostly a small hot set so loads see earlier stores
			base = sb.reg_value(r.second_reg);
			word = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MEM_WORDS - 1)
				: $urandom_range(0, 31);
			r.imm = (word << 2) - base;
			case ($urandom_range(0, 11))
			0: r.imm = r.imm + $urandom_range(1, 3);
			1: r.imm = r.imm + (MEM_WORDS << 2);
			2: r.imm = -((word + 1) << 2) - base;
			3: r.imm = $urandom();
			default: ;
			endcase
		end else if ((r.op == OP_BNE || r.op == OP_BEQ) && $urandom_range(0, 1)) begin
			if (r.use_imm) r.imm = sb.reg_value(r.first_reg);
			else r.second_reg = r.first_reg;
		end
		return r;
	endfunction

	// valid stays high into the next request when no gap is drawn
	task automatic send_request(input req_t item);
		int gap;
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(item);
		gap = draw_wait(send_burst);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic run_receiver();
		int stall;
		forever begin
			stall = draw_wait(recv_burst);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			sb.check_result(res);
		end
	endtask

	task automatic run_directed();
		// arithmetic corners: r1 max, r2 minus one, r31 min
		send_request(make_req(OP_ADDI, 5'd1, 5'd0, 5'd0, 1'b0, 32'h7FFF_FFFF, 16'd0, 16'd0));
		send_request(make_req(OP_ADDI, 5'd2, 5'd0, 5'd31, 1'b1, 32'hFFFF_FFFF, 16'd1, 16'd9));
		send_request(make_req(OP_ADDI, 5'd31, 5'd0, 5'd0, 1'b0, 32'h8000_0000, 16'd2, 16'd0));
		send_request(make_req(OP_ADD, 5'd3, 5'd1, 5'd2, 1'b0, 32'h0, 16'd3, 16'd0));
		send_request(make_req(OP_ADD, 5'd4, 5'd1, 5'd0, 1'b1, 32'h1, 16'd4, 16'd0));
		send_request(make_req(OP_SUB, 5'd5, 5'd31, 5'd1, 1'b0, 32'h0, 16'd5, 16'd0));
		send_request(make_req(OP_MUL, 5'd6, 5'd1, 5'd1, 1'b0, 32'h0, 16'd6, 16'd0));
		send_request(make_req(OP_SLT, 5'd7, 5'd31, 5'd1, 1'b0, 32'h0, 16'd7, 16'd0));
		send_request(make_req(OP_SLT, 5'd8, 5'd1, 5'd0, 1'b1, 32'hFFFF_FFFF, 16'd8, 16'd0));
		// writes to the zero register
		send_request(make_req(OP_ADDI, 5'd0, 5'd1, 5'd0, 1'b0, 32'h5, 16'd9, 16'd0));
		send_request(make_req(OP_MUL, 5'd0, 5'd1, 5'd2, 1'b0, 32'h0, 16'd10, 16'd0));
		// jumps and branches, line extremes
		send_request(make_req(OP_J, 5'd31, 5'd31, 5'd31, 1'b1, 32'hFFFF_FFFF, 16'd0, 16'hFFFF));
		send_request(make_req(OP_BNE, 5'd1, 5'd1, 5'd0, 1'b0, 32'h0, 16'hFFFF, 16'd0));
		send_request(make_req(OP_BNE, 5'd1, 5'd0, 5'd0, 1'b1, 32'h5, 16'd12, 16'd100));
		send_request(make_req(OP_BEQ, 5'd2, 5'd0, 5'd0, 1'b1, 32'hFFFF_FFFF, 16'd13, 16'd200));
		send_request(make_req(OP_BEQ, 5'd1, 5'd2, 5'd0, 1'b0, 32'h0, 16'd14, 16'd300));
		// memory faults in priority order
		send_request(make_req(OP_SW, 5'd0, 5'd0, 5'd0, 1'b0, 32'h1, 16'd15, 16'd0));
		send_request(make_req(OP_SW, 5'd1, 5'd0, 5'd0, 1'b0, 32'hFFFF_FFFE, 16'd16, 16'd0));
		send_request(make_req(OP_SW, 5'd1, 5'd31, 5'd0, 1'b0, 32'h0, 16'd17, 16'd0));
		send_request(make_req(OP_SW, 5'd1, 5'd0, 5'd0, 1'b0, MEM_WORDS << 2, 16'd18, 16'd0));
		// last word of memory, and address zero reached through wraparound
		send_request(make_req(OP_SW, 5'd1, 5'd0, 5'd0, 1'b0, (MEM_WORDS - 1) << 2, 16'd19,
			16'd0));
		send_request(make_req(OP_LW, 5'd9, 5'd0, 5'd0, 1'b0, (MEM_WORDS - 1) << 2, 16'd20,
			16'd0));
		send_request(make_req(OP_LW, 5'd10, 5'd2, 5'd0, 1'b0, 32'h1, 16'd21, 16'd0));
		send_request(make_req(OP_LW, 5'd0, 5'd0, 5'd0, 1'b0, 32'h0, 16'd22, 16'd0));
		// undefined op codes
		send_request(make_req(4'(OP_KINDS), 5'd3, 5'd1, 5'd2, 1'b0, 32'h0, 16'd23, 16'd7));
		send_request(make_req(OP_CODE_MAX, 5'd31, 5'd31, 5'd31, 1'b1, 32'hFFFF_FFFF, 16'd24,
			16'hFFFF));
	endtask

	initial begin
		int i;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		res_ready = 1'b0;
		req = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		fork
			run_receiver();
		join_none
		run_directed();
		hold_until_drained();
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			send_request(random_request());
			if ($urandom_range(0, 299) == 0) hold_until_drained();
		end
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
